// File: design/mccc_pkg.sv
// Shared types, sizes and helper functions for the marching-cubes cell classifier.
// Used by the top level. Has no dependencies of its own.
`timescale 1ns / 1ps

package mccc_pkg;

   // Grid and sample sizing.
   localparam int MAX_DIM      = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int ISO_BITS     = 16;
   localparam int GRID_RESET   = 32;
   localparam int CORNER_COUNT = 8;

   // Derived widths.
   localparam int DIM_BITS       = $clog2(MAX_DIM + 1);
   localparam int POS_BITS       = $clog2(MAX_DIM);
   localparam int PLANE_BITS     = $clog2(MAX_DIM * MAX_DIM);
   localparam int PLANE_LEN_BITS = $clog2(MAX_DIM * MAX_DIM + 1);

   // Configuration port sizing.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Cube index of a cell with every corner below the iso value.
   localparam logic [CORNER_COUNT-1:0] CUBE_ALL = 8'hFF;
   localparam logic [CORNER_COUNT-1:0] CUBE_NONE = 8'h00;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ISO_VALUE = 2'd0,
      CSR_GRID_X    = 2'd1,
      CSR_GRID_Y    = 2'd2,
      CSR_GRID_Z    = 2'd3
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CORNER_COUNT-1:0][SAMPLE_BITS-1:0] corners_type;

   // Grid sizes below two act as two, sizes above the maximum act as the maximum.
   function automatic logic [DIM_BITS-1:0] clamp_dim_f(input logic [DIM_BITS-1:0] d);
      logic [DIM_BITS-1:0] r;
      if (d < DIM_BITS'(2)) begin
         r = DIM_BITS'(2);
      end else if (d > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

   // One bit per corner, set when that corner lies strictly below the iso value.
   function automatic logic [CORNER_COUNT-1:0] cube_index_f(
      input corners_type                 c,
      input logic signed [ISO_BITS-1:0]  iso
   );
      logic [CORNER_COUNT-1:0] idx;
      for (int n = 0; n < CORNER_COUNT; n++) begin
         idx[n] = ($signed(c[n]) < iso);
      end
      return idx;
   endfunction

endpackage

// File: design/mccc_ram.sv
// Generic single-port RAM with read-before-write and registered read data.
// Used as a circular delay line by the classifier top level. No package needed.
`timescale 1ns / 1ps

module mccc_ram #(
   parameter int ADDR_BITS = 5,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // The old entry is read out in the same cycle the new one replaces it.
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/marching_cubes_cell_classifier_top.sv
// Top level of the marching-cubes cell classifier: delay lines, position tracking,
// corner compare and result register. Depends on mccc_pkg and mccc_ram.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_sample
//   rsp      out        rsp_valid / rsp_stall  rsp_cell_x/y/z, rsp_cube_index, rsp_corner_0..7
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One sample is accepted per cycle when not stalled; it is staged, then any result registered.
// The rate is set by the single registered compare pass and the one read per delay-line RAM.
// Reset is synchronous; no clearing pass is run, the delay lines are read only once written.
// A stall on rsp holds the result and the staged sample; req_stall rises at once when a
// sample is staged behind the held result.
// A write to a grid register restarts the grid position and the delay-line pointers.
`timescale 1ns / 1ps

module marching_cubes_cell_classifier_top
   import mccc_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [POS_BITS-1:0]        rsp_cell_x,
   output logic        [POS_BITS-1:0]        rsp_cell_y,
   output logic        [POS_BITS-1:0]        rsp_cell_z,
   output logic        [CORNER_COUNT-1:0]    rsp_cube_index,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_0,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_1,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_2,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_3,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_4,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_5,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_6,
   output logic signed [SAMPLE_BITS-1:0]     rsp_corner_7,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic        [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic        [CSR_DATA_BITS-1:0]   csr_data
);

   // Configuration registers.
   logic signed [ISO_BITS-1:0] iso_ff;
   logic [DIM_BITS-1:0]        gx_ff;
   logic [DIM_BITS-1:0]        gy_ff;
   logic [DIM_BITS-1:0]        gz_ff;
   logic                       csr_we;
   logic                       restart;
   csr_index_type              csr_sel;

   // Position and delay-line pointers.
   logic [POS_BITS-1:0]       pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]       pos_y_ff, pos_y_in;
   logic [POS_BITS-1:0]       pos_z_ff, pos_z_in;
   logic [POS_BITS-1:0]       row_ptr_ff, row_ptr_in;
   logic [POS_BITS-1:0]       cross_ptr_ff, cross_ptr_in;
   logic [PLANE_BITS-1:0]     plane_ptr_ff, plane_ptr_in;
   logic [PLANE_LEN_BITS-1:0] plane_len;
   logic                      z_wrap, y_wrap, x_wrap;
   logic                      row_wrap, cross_wrap, plane_wrap;

   // Handshake and stage control.
   logic req_accept;
   logic out_free;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic emit;

   // Delay-line read data.
   logic [SAMPLE_BITS-1:0] row_rd;
   logic [SAMPLE_BITS-1:0] plane_rd;
   logic [SAMPLE_BITS-1:0] cross_rd;

   // Staged sample and its neighbors one step back.
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   s1_close_ff;
   logic [POS_BITS-1:0]    s1_cell_x_ff, s1_cell_y_ff, s1_cell_z_ff;
   logic [SAMPLE_BITS-1:0] prev_sample_ff;
   logic [SAMPLE_BITS-1:0] prev_row_ff;
   logic [SAMPLE_BITS-1:0] prev_plane_ff;
   logic [SAMPLE_BITS-1:0] prev_cross_ff;

   corners_type             corners;
   logic [CORNER_COUNT-1:0] cube_idx;

   // Result register.
   logic [POS_BITS-1:0]     rsp_cell_x_ff, rsp_cell_y_ff, rsp_cell_z_ff;
   logic [CORNER_COUNT-1:0] rsp_cube_index_ff;
   corners_type             rsp_corners_ff;

   // The configuration port never pushes back.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign csr_sel   = csr_index_type'(csr_index);
   assign restart   = csr_we && (csr_sel != CSR_ISO_VALUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= '0;
         gx_ff  <= clamp_dim_f(DIM_BITS'(GRID_RESET));
         gy_ff  <= clamp_dim_f(DIM_BITS'(GRID_RESET));
         gz_ff  <= clamp_dim_f(DIM_BITS'(GRID_RESET));
      end else if (csr_we) begin
         unique case (csr_sel)
            CSR_ISO_VALUE: iso_ff <= csr_data[ISO_BITS-1:0];
            CSR_GRID_X:    gx_ff  <= clamp_dim_f(csr_data[DIM_BITS-1:0]);
            CSR_GRID_Y:    gy_ff  <= clamp_dim_f(csr_data[DIM_BITS-1:0]);
            CSR_GRID_Z:    gz_ff  <= clamp_dim_f(csr_data[DIM_BITS-1:0]);
         endcase
      end
   end

   // Handshake: a new request enters whenever the staged one can move on.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Wrap points of the position counters and the three circular delay lines.
   // The row line is gz long, the plane line gy*gz, the cross line gz-1.
   assign plane_len  = PLANE_LEN_BITS'(gy_ff) * PLANE_LEN_BITS'(gz_ff);
   assign z_wrap     = ({1'b0, pos_z_ff} == gz_ff - DIM_BITS'(1));
   assign y_wrap     = ({1'b0, pos_y_ff} == gy_ff - DIM_BITS'(1));
   assign x_wrap     = ({1'b0, pos_x_ff} == gx_ff - DIM_BITS'(1));
   assign row_wrap   = ({1'b0, row_ptr_ff} == gz_ff - DIM_BITS'(1));
   assign cross_wrap = ({1'b0, cross_ptr_ff} == gz_ff - DIM_BITS'(2));
   assign plane_wrap = ({1'b0, plane_ptr_ff} == plane_len - PLANE_LEN_BITS'(1));

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      row_ptr_in   = row_ptr_ff;
      cross_ptr_in = cross_ptr_ff;
      plane_ptr_in = plane_ptr_ff;
      if (restart) begin
         pos_x_in     = '0;
         pos_y_in     = '0;
         pos_z_in     = '0;
         row_ptr_in   = '0;
         cross_ptr_in = '0;
         plane_ptr_in = '0;
      end else if (req_accept) begin
         row_ptr_in   = row_wrap   ? '0 : row_ptr_ff + POS_BITS'(1);
         cross_ptr_in = cross_wrap ? '0 : cross_ptr_ff + POS_BITS'(1);
         plane_ptr_in = plane_wrap ? '0 : plane_ptr_ff + PLANE_BITS'(1);
         // Raster order: z fastest, then y, then x.
         if (!z_wrap) begin
            pos_z_in = pos_z_ff + POS_BITS'(1);
         end else begin
            pos_z_in = '0;
            if (!y_wrap) begin
               pos_y_in = pos_y_ff + POS_BITS'(1);
            end else begin
               pos_y_in = '0;
               pos_x_in = x_wrap ? '0 : pos_x_ff + POS_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         row_ptr_ff   <= '0;
         cross_ptr_ff <= '0;
         plane_ptr_ff <= '0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         row_ptr_ff   <= row_ptr_in;
         cross_ptr_ff <= cross_ptr_in;
         plane_ptr_ff <= plane_ptr_in;
      end
   end

   // Sample one row back.
   mccc_ram #(
      .ADDR_BITS (POS_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_row_ram (
      .clock   (clock),
      .en      (req_accept),
      .addr    (row_ptr_ff),
      .wr_data (req_sample),
      .rd_data (row_rd)
   );

   // Sample one plane back.
   mccc_ram #(
      .ADDR_BITS (PLANE_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_plane_ram (
      .clock   (clock),
      .en      (req_accept),
      .addr    (plane_ptr_ff),
      .wr_data (req_sample),
      .rd_data (plane_rd)
   );

   // Sample one plane and one row back. It is fed by the plane line's previous
   // output, which already lags one step, so this line is one shorter than a row.
   mccc_ram #(
      .ADDR_BITS (POS_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_cross_ram (
      .clock   (clock),
      .en      (req_accept),
      .addr    (cross_ptr_ff),
      .wr_data (plane_rd),
      .rd_data (cross_rd)
   );

   // Stage valid bits.
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage the request; the previous step's values become the one-back neighbors.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff   <= req_sample;
         s1_close_ff    <= (pos_x_ff != '0) && (pos_y_ff != '0) && (pos_z_ff != '0);
         s1_cell_x_ff   <= pos_x_ff - POS_BITS'(1);
         s1_cell_y_ff   <= pos_y_ff - POS_BITS'(1);
         s1_cell_z_ff   <= pos_z_ff - POS_BITS'(1);
         prev_sample_ff <= s1_sample_ff;
         prev_row_ff    <= row_rd;
         prev_plane_ff  <= plane_rd;
         prev_cross_ff  <= cross_rd;
      end
   end

   // Gather the eight corners in the cube-index order and classify.
   always_comb begin
      corners[0] = prev_cross_ff;
      corners[1] = prev_row_ff;
      corners[2] = row_rd;
      corners[3] = cross_rd;
      corners[4] = prev_plane_ff;
      corners[5] = prev_sample_ff;
      corners[6] = s1_sample_ff;
      corners[7] = plane_rd;
   end

   assign cube_idx = cube_index_f(corners, iso_ff);
   assign emit     = s1_valid_ff && s1_close_ff &&
                     (cube_idx != CUBE_NONE) && (cube_idx != CUBE_ALL);

   // Result register: loaded only with cells that cross the surface.
   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_cell_x_ff     <= s1_cell_x_ff;
         rsp_cell_y_ff     <= s1_cell_y_ff;
         rsp_cell_z_ff     <= s1_cell_z_ff;
         rsp_cube_index_ff <= cube_idx;
         rsp_corners_ff    <= corners;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_x     = rsp_cell_x_ff;
   assign rsp_cell_y     = rsp_cell_y_ff;
   assign rsp_cell_z     = rsp_cell_z_ff;
   assign rsp_cube_index = rsp_cube_index_ff;
   assign rsp_corner_0   = rsp_corners_ff[0];
   assign rsp_corner_1   = rsp_corners_ff[1];
   assign rsp_corner_2   = rsp_corners_ff[2];
   assign rsp_corner_3   = rsp_corners_ff[3];
   assign rsp_corner_4   = rsp_corners_ff[4];
   assign rsp_corner_5   = rsp_corners_ff[5];
   assign rsp_corner_6   = rsp_corners_ff[6];
   assign rsp_corner_7   = rsp_corners_ff[7];

   // A shown result always has a mixed cube index.
   a_rsp_mixed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cube_index_ff != CUBE_NONE) && (rsp_cube_index_ff != CUBE_ALL))
      else $error("result shown with a uniform cube index");

   // The position stays inside the configured grid.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_z_ff} < gz_ff) && ({1'b0, pos_y_ff} < gy_ff) && ({1'b0, pos_x_ff} < gx_ff))
      else $error("grid position outside the configured grid");

   // The plane delay-line pointer stays below the plane length.
   a_plane_ptr: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, plane_ptr_ff} < plane_len))
      else $error("plane pointer beyond the plane length");

   // An accepted request is always staged in the next cycle.
   a_stage_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request not staged");

endmodule
